FILE: rtl/ub2x_pkg.sv
// shared types, constants and tap table for the 2x upsample and blur block
// no dependencies; used by ub2x_ctrl, ub2x_dp and upsample_blur_2x
package ub2x_pkg;

    localparam int SRC_MAX_DIM_DEF = 256;
    localparam int PIXEL_BITS_DEF  = 32;

    localparam int POS_W   = 9;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 10;
    localparam int SRCD_W  = 9;
    localparam int DSTD_W  = 10;
    localparam int NUM_TAPS = 9;
    localparam int TAP_W   = 4;
    localparam int DIV_BITS_PER_CYC = 8;

    localparam logic [SRCD_W-1:0] SRC_W_RST = 9'd256;
    localparam logic [SRCD_W-1:0] SRC_H_RST = 9'd256;
    localparam logic [DSTD_W-1:0] DST_W_RST = 10'd512;
    localparam logic [DSTD_W-1:0] DST_H_RST = 10'd512;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        W_CENTER,
        W_ORTH,
        W_DIAG
    } t_weight;

    typedef struct packed {
        logic                     operation;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic signed [WORD_W-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] pixel_out;
        logic                     coord_error;
    } t_out_word;

    // neighbor offset flags: minus / plus on each axis
    typedef struct packed {
        logic xm;
        logic xp;
        logic ym;
        logic yp;
    } t_tap;

    typedef struct packed {
        logic             latch;
        logic             tap_en;
        logic [TAP_W-1:0] tap_idx;
        logic             div_init;
        logic             div_step;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic read_ok;
        logic out_free;
    } t_dp_status;

    // center first, then the eight neighbors row by row
    function automatic t_tap tap_offset(input logic [TAP_W-1:0] idx);
        t_tap t;
        t = '0;
        case (idx)
            4'd1: begin t.xm = 1'b1; t.ym = 1'b1; end
            4'd2: begin t.ym = 1'b1; end
            4'd3: begin t.xp = 1'b1; t.ym = 1'b1; end
            4'd4: begin t.xm = 1'b1; end
            4'd5: begin t.xp = 1'b1; end
            4'd6: begin t.xm = 1'b1; t.yp = 1'b1; end
            4'd7: begin t.yp = 1'b1; end
            4'd8: begin t.xp = 1'b1; t.yp = 1'b1; end
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic t_weight tap_weight(input t_tap t);
        logic mx;
        logic my;
        mx = t.xm | t.xp;
        my = t.ym | t.yp;
        if (mx && my) begin
            return W_DIAG;
        end else if (mx || my) begin
            return W_ORTH;
        end
        return W_CENTER;
    endfunction

endpackage

FILE: rtl/ub2x_ctrl.sv
// sequencer for the 2x upsample and blur block: accept, tap reads, divide, result
// depends on ub2x_pkg
module ub2x_ctrl #(
    parameter int DIV_ITERS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ub2x_pkg::t_dp_status i_status,
    output ub2x_pkg::t_dp_cmd    o_cmd
);
    import ub2x_pkg::*;

    localparam int CNT_W = $clog2(DIV_ITERS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_ITERS - 1);
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(NUM_TAPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_ACC,
        S_INIT,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.tap_idx = r_tap;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_tap = '0;
                    n_state = i_status.read_ok ? S_TAP : S_DONE;
                end
            end
            S_TAP: begin
                o_cmd.tap_en = 1'b1;
                n_tap = r_tap + 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_state = S_ACC;
                end
            end
            // last tap lands in the accumulator
            S_ACC: begin
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/ub2x_dp.sv
// datapath: config registers, source pixel memory, tap accumulator, divider, output reg
// depends on ub2x_pkg
module ub2x_dp #(
    parameter int SRC_MAX_DIM = 256,
    parameter int PIXEL_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ub2x_pkg::t_dp_cmd             i_cmd,
    input  ub2x_pkg::t_in_word            i_in_word,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [ub2x_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_out_ready,
    output ub2x_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    output ub2x_pkg::t_out_word           o_out_word
);
    import ub2x_pkg::*;

    localparam int AW    = (SRC_MAX_DIM > 1) ? $clog2(SRC_MAX_DIM) : 1;
    localparam int DEPTH = 1 << (2 * AW);
    localparam int CW    = 11;
    localparam int SUMW  = PIXEL_BITS + 6;
    localparam int MAGW  = ((SUMW + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC)
                           * DIV_BITS_PER_CYC;
    localparam logic [CW-1:0] MAX_DIM = CW'(SRC_MAX_DIM);

    // configuration
    logic [SRCD_W-1:0] r_src_w, r_src_h;
    logic [DSTD_W-1:0] r_dst_w, r_dst_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W_RST;
            r_src_h <= SRC_H_RST;
            r_dst_w <= DST_W_RST;
            r_dst_h <= DST_H_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRCD_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRCD_W-1:0];
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // source size saturates at the store dimension
    logic [CW-1:0] sw, sh;
    assign sw = (CW'(r_src_w) > MAX_DIM) ? MAX_DIM : CW'(r_src_w);
    assign sh = (CW'(r_src_h) > MAX_DIM) ? MAX_DIM : CW'(r_src_h);

    // checks on the incoming word
    logic wr_err, rd_err, acc_err;
    assign wr_err = (CW'(i_in_word.pos_x) >= sw) || (CW'(i_in_word.pos_y) >= sh);
    assign rd_err = (DSTD_W'(i_in_word.pos_x) >= r_dst_w)
                 || (DSTD_W'(i_in_word.pos_y) >= r_dst_h)
                 || (sw == '0) || (sh == '0);
    assign acc_err = (i_in_word.operation == OP_READ) ? rd_err : wr_err;

    logic             r_op, r_err;
    logic [POS_W-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_in_word.operation;
            r_err <= acc_err;
            r_x   <= i_in_word.pos_x;
            r_y   <= i_in_word.pos_y;
        end
    end

    // tap address
    t_tap              tap;
    t_weight           tap_w;
    logic [DSTD_W-1:0] nx, ny;
    logic              tap_ok;
    logic [SRCD_W-1:0] sx9, sy9;
    logic [CW-1:0]     sxc, syc;
    logic [2*AW-1:0]   rd_addr, wr_addr, mem_addr;

    always_comb begin
        tap   = tap_offset(i_cmd.tap_idx);
        tap_w = tap_weight(tap);
        nx = DSTD_W'(r_x);
        ny = DSTD_W'(r_y);
        if (tap.xp) nx = nx + 1'b1;
        if (tap.xm) nx = nx - 1'b1;
        if (tap.yp) ny = ny + 1'b1;
        if (tap.ym) ny = ny - 1'b1;
        tap_ok = !(tap.xm && (r_x == '0)) && !(tap.ym && (r_y == '0))
              && (nx < r_dst_w) && (ny < r_dst_h);
        sx9 = nx[DSTD_W-1:1];
        sy9 = ny[DSTD_W-1:1];
        sxc = (CW'(sx9) >= sw) ? (sw - 1'b1) : CW'(sx9);
        syc = (CW'(sy9) >= sh) ? (sh - 1'b1) : CW'(sy9);
        rd_addr = {syc[AW-1:0], sxc[AW-1:0]};
    end

    logic [CW-1:0] wx, wy;
    logic          mem_we;
    assign wx = CW'(i_in_word.pos_x);
    assign wy = CW'(i_in_word.pos_y);
    assign wr_addr = {wy[AW-1:0], wx[AW-1:0]};
    assign mem_we  = i_cmd.latch && (i_in_word.operation == OP_WRITE) && !wr_err;
    assign mem_addr = mem_we ? wr_addr : rd_addr;

    // source pixel store, one access a cycle
    logic signed [PIXEL_BITS-1:0] mem [0:DEPTH-1];
    logic signed [PIXEL_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= PIXEL_BITS'(i_in_word.pixel_in);
        end
        if (i_cmd.tap_en) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // accumulate in the cycle after the read
    logic    r_acc_v;
    t_weight r_acc_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.tap_en && tap_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_w <= tap_w;
    end

    logic signed [SUMW-1:0] r_sum, ext_val, add_val;
    logic [4:0]             r_dsum, add_w;

    always_comb begin
        ext_val = SUMW'(r_rdata);
        case (r_acc_w)
            W_CENTER: begin add_val = ext_val <<< 4; add_w = 5'd16; end
            W_ORTH:   begin add_val = ext_val <<< 1; add_w = 5'd2;  end
            W_DIAG:   begin add_val = ext_val;       add_w = 5'd1;  end
            default:  begin add_val = '0;            add_w = 5'd0;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sum  <= '0;
            r_dsum <= '0;
        end else if (r_acc_v) begin
            r_sum  <= r_sum + add_val;
            r_dsum <= r_dsum + add_w;
        end
    end

    // restoring divide of the magnitude, several quotient bits a cycle
    logic            r_neg;
    logic [MAGW-1:0] r_mag, n_mag;
    logic [4:0]      r_rem, n_rem;
    logic [5:0]      rem6;
    logic [SUMW-1:0] abs_sum;

    assign abs_sum = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);

    always_comb begin
        n_mag = r_mag;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
            rem6  = {n_rem, n_mag[MAGW-1]};
            n_mag = n_mag << 1;
            if (rem6 >= {1'b0, r_dsum}) begin
                rem6     = rem6 - {1'b0, r_dsum};
                n_mag[0] = 1'b1;
            end
            n_rem = rem6[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= r_sum[SUMW-1];
            r_mag <= MAGW'(abs_sum);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    logic [PIXEL_BITS-1:0]        q_mag;
    logic signed [PIXEL_BITS-1:0] q_val;
    assign q_mag = r_mag[PIXEL_BITS-1:0];
    assign q_val = r_neg ? -q_mag : q_mag;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word, n_out_word;

    always_comb begin
        n_out_word.coord_error = r_err;
        if ((r_op == OP_READ) && !r_err) begin
            n_out_word.pixel_out = WORD_W'(q_val);
        end else begin
            n_out_word.pixel_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_status.read_ok  = (i_in_word.operation == OP_READ) && !rd_err;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/upsample_blur_2x.sv
// top level of the 2x nearest upsample with 3x3 blur
// depends on ub2x_pkg, ub2x_ctrl and ub2x_dp
//
// input channel (valid/ready) carries one word: a source pixel write, or a
// request for one destination pixel. every accepted word gives exactly one
// result word on the output channel, in order.
// a write stores the pixel in the cycle it is accepted, and its result
// goes through the final state to the output register. a read without a
// coordinate error walks the nine taps through the single-port source
// store, one read a cycle, then divides by the weight total with a
// restoring divider taking 8 quotient bits a cycle; a read with one goes
// straight to the final state. the block holds one word at a time and is
// ready again the cycle after its result is loaded into the output register.
// the output register holds its word until taken; a stalled receiver holds
// the block in its final state, while one finished word may wait there.
// reset clears control state and loads the default sizes; the store is not
// cleared, and reading a never-written pixel gives an undefined value.
// the user must write sizes through the config port only while the block is idle; the block does not enforce this.
module upsample_blur_2x #(
    parameter int SRC_MAX_DIM = ub2x_pkg::SRC_MAX_DIM_DEF,
    parameter int PIXEL_BITS  = ub2x_pkg::PIXEL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ub2x_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ub2x_pkg::t_out_word        o_out_word,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [ub2x_pkg::CFG_W-1:0] i_cfg_data
);
    import ub2x_pkg::*;

    localparam int SUMW = PIXEL_BITS + 6;
    localparam int DIV_ITERS = (SUMW + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;

    t_dp_cmd    cmd;
    t_dp_status status;

    ub2x_ctrl #(
        .DIV_ITERS (DIV_ITERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ub2x_dp #(
        .SRC_MAX_DIM (SRC_MAX_DIM),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: sim/tb_upsample_blur_2x.sv
// self-checking testbench for upsample_blur_2x: 2x nearest upsample with 3x3 blur
// drives random and directed words, predicts each result in-line; depends on ub2x_pkg
`timescale 1ns / 100ps

module tb_upsample_blur_2x;

    import ub2x_pkg::*;

    localparam int SRC_MAX = SRC_MAX_DIM_DEF;
    localparam logic [31:0] PIX_MIN = 32'h8000_0000;
    localparam logic [31:0] PIX_MAX = 32'h7FFF_FFFF;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    t_in_word        in_word   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    t_out_word       out_word;
    logic            cfg_we    = 1'b0;
    logic [1:0]      cfg_idx   = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // register copies, kept in step with the writes below
    logic [SRCD_W-1:0] src_w = SRC_W_RST;
    logic [SRCD_W-1:0] src_h = SRC_H_RST;
    logic [DSTD_W-1:0] dst_w = DST_W_RST;
    logic [DSTD_W-1:0] dst_h = DST_H_RST;

    logic signed [31:0] pix_mem [0:SRC_MAX*SRC_MAX-1];
    bit                 gen_written [0:SRC_MAX*SRC_MAX-1];

    t_in_word  in_words_q[$];
    t_out_word pixel_results_q[$];

    int errors     = 0;
    int words_out  = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int mode       = 0;
    int mode_left  = 0;
    int stall_cyc  = 0;

    upsample_blur_2x uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [SRCD_W-1:0] d);
        return (d > SRC_MAX) ? SRC_MAX : int'(d);
    endfunction

    // applies one accepted word to the pixel store copy and returns its result
    function automatic t_out_word blur_and_store(input t_in_word w);
        t_out_word r;
        int sw, sh, dw, dh, px, py, nx, ny, sx, sy, dxo, dyo, wt, wsum;
        longint acc;
        r = '0;
        sw = eff_dim(src_w);
        sh = eff_dim(src_h);
        dw = int'(dst_w);
        dh = int'(dst_h);
        px = int'(w.pos_x);
        py = int'(w.pos_y);
        if (w.operation == OP_WRITE) begin
            if (px >= sw || py >= sh) begin
                r.coord_error = 1'b1;
            end else begin
                pix_mem[py*SRC_MAX + px] = w.pixel_in;
            end
            return r;
        end
        if (px >= dw || py >= dh || sw == 0 || sh == 0) begin
            r.coord_error = 1'b1;
            return r;
        end
        acc  = 0;
        wsum = 0;
        for (dyo = -1; dyo <= 1; dyo++) begin
            for (dxo = -1; dxo <= 1; dxo++) begin
                nx = px + dxo;
                ny = py + dyo;
                if (nx >= 0 && ny >= 0 && nx < dw && ny < dh) begin
                    if (dxo == 0 && dyo == 0) begin
                        wt = 16;
                    end else if (dxo != 0 && dyo != 0) begin
                        wt = 1;
                    end else begin
                        wt = 2;
                    end
                    sx = nx / 2;
                    sy = ny / 2;
                    if (sx >= sw) sx = sw - 1;
                    if (sy >= sh) sy = sh - 1;
                    acc  += wt * longint'(pix_mem[sy*SRC_MAX + sx]);
                    wsum += wt;
                end
            end
        end
        r.pixel_out = 32'(acc / wsum);
        return r;
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return PIX_MIN;
            1: return PIX_MAX;
            default: return $urandom;
        endcase
    endfunction

    // queues a word; a read is preceded by writes to any source pixel it would touch
    // that has not been written yet
    task automatic queue_word(input t_op op, input int x, input int y, input logic [31:0] v);
        t_in_word w;
        int sw, sh, nx, ny, sx, sy, dxo, dyo;
        sw = eff_dim(src_w);
        sh = eff_dim(src_h);
        if (op == OP_READ && x < int'(dst_w) && y < int'(dst_h) && sw > 0 && sh > 0) begin
            for (dyo = -1; dyo <= 1; dyo++) begin
                for (dxo = -1; dxo <= 1; dxo++) begin
                    nx = x + dxo;
                    ny = y + dyo;
                    if (nx >= 0 && ny >= 0) begin
                        sx = nx / 2;
                        sy = ny / 2;
                        if (sx >= sw) sx = sw - 1;
                        if (sy >= sh) sy = sh - 1;
                        if (!gen_written[sy*SRC_MAX + sx]) begin
                            w.operation = OP_WRITE;
                            w.pos_x     = POS_W'(sx);
                            w.pos_y     = POS_W'(sy);
                            w.pixel_in  = rand_pixel();
                            in_words_q  = {in_words_q, w};
                            gen_written[sy*SRC_MAX + sx] = 1'b1;
                        end
                    end
                end
            end
        end
        if (op == OP_WRITE && x < sw && y < sh) gen_written[y*SRC_MAX + x] = 1'b1;
        w.operation = op;
        w.pos_x     = POS_W'(x);
        w.pos_y     = POS_W'(y);
        w.pixel_in  = v;
        in_words_q  = {in_words_q, w};
    endtask

    task automatic set_reg(input t_cfg_idx idx, input int v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  src_w = SRCD_W'(v);
            CFG_SRC_HEIGHT: src_h = SRCD_W'(v);
            CFG_DST_WIDTH:  dst_w = DSTD_W'(v);
            CFG_DST_HEIGHT: dst_h = DSTD_W'(v);
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
        set_reg(CFG_SRC_WIDTH, sw);
        set_reg(CFG_SRC_HEIGHT, sh);
        set_reg(CFG_DST_WIDTH, dw);
        set_reg(CFG_DST_HEIGHT, dh);
    endtask

    // sender stays off until every queued word has come back out
    task automatic drain();
        while (in_words_q.size() != 0 || in_valid || pixel_results_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (24) @(posedge clk);
    endtask

    function automatic int pick_src_dim();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return $urandom_range(257, 511);
            4, 5, 6: return $urandom_range(9, 256);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_dst_dim(input int s);
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 1;
            2: return 512;
            3: return 1023;
            4, 5, 6: return $urandom_range(1, 512);
            default: return $urandom_range(1, 2*s + 3);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 200) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // driver: predicts on accept, then offers the next word in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                pixel_results_q = {pixel_results_q, blur_and_store(in_word)};
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (in_words_q.size() > 0) begin
                    in_word  <= in_words_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken word and drives ready on a pattern of its own
    always @(posedge clk) begin
        logic       rdy;
        t_out_word  want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pixel_results_q.size() == 0) begin
                    flag_error($sformatf("unexpected word %h", out_word));
                end else begin
                    want = pixel_results_q.pop_front();
                    if (out_word.pixel_out !== want.pixel_out) begin
                        flag_error($sformatf("word %0d pixel_out got %h want %h",
                                             words_out, out_word.pixel_out, want.pixel_out));
                    end
                    if (out_word.coord_error !== want.coord_error) begin
                        flag_error($sformatf("word %0d coord_error got %b want %b",
                                             words_out, out_word.coord_error,
                                             want.coord_error));
                    end
                end
                words_out++;
                // long hold-off so the block backs up into its input
                if (words_out == 250 || words_out == 900) hold_left = 500;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            stall_cyc++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ((stall_cyc % 7) < 4);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            out_ready <= rdy;
        end
    end

    initial begin
        int r, x, y, dw, dh, sw, sh, target, ph;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: full-scale values, corners, and source-side coordinate errors
        queue_word(OP_WRITE, 0, 0, PIX_MIN);
        queue_word(OP_WRITE, 1, 0, PIX_MIN);
        queue_word(OP_WRITE, 0, 1, PIX_MIN);
        queue_word(OP_WRITE, 1, 1, PIX_MIN);
        queue_word(OP_READ, 0, 0, '0);
        queue_word(OP_READ, 1, 1, '0);
        queue_word(OP_WRITE, 255, 255, PIX_MAX);
        queue_word(OP_READ, 511, 511, '0);
        queue_word(OP_WRITE, 2, 0, PIX_MAX);
        queue_word(OP_READ, 3, 0, '0);
        queue_word(OP_WRITE, 256, 5, PIX_MAX);
        queue_word(OP_WRITE, 5, 256, PIX_MAX);
        queue_word(OP_WRITE, 511, 511, PIX_MIN);
        drain();

        // single-pixel frames: centre weight alone, every neighbour dropped
        set_sizes(1, 1, 1, 1);
        queue_word(OP_WRITE, 0, 0, PIX_MAX);
        queue_word(OP_READ, 0, 0, '0);
        queue_word(OP_WRITE, 1, 0, PIX_MIN);
        queue_word(OP_READ, 1, 0, '0);
        queue_word(OP_READ, 0, 1, '0);
        drain();

        // empty source: every write and read is out of range
        set_sizes(0, 0, 512, 512);
        queue_word(OP_WRITE, 0, 0, PIX_MAX);
        queue_word(OP_READ, 3, 3, '0);
        drain();

        // oversize registers saturate the source, destination wider than any x
        set_sizes(511, 511, 1023, 1023);
        queue_word(OP_WRITE, 255, 0, PIX_MAX);
        queue_word(OP_READ, 511, 0, '0);
        queue_word(OP_READ, 0, 511, '0);
        drain();

        // destination past twice the source: clamp to the last source pixel
        set_sizes(2, 2, 9, 7);
        queue_word(OP_READ, 8, 6, '0);
        queue_word(OP_READ, 4, 3, '0);
        drain();

        for (ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                set_sizes(256, 256, 512, 512);
            end else begin
                sw = pick_src_dim();
                sh = pick_src_dim();
                set_sizes(sw, sh, pick_dst_dim(eff_dim(SRCD_W'(sw))),
                          pick_dst_dim(eff_dim(SRCD_W'(sh))));
            end
            sw = eff_dim(src_w);
            sh = eff_dim(src_h);
            dw = (int'(dst_w) > 512) ? 512 : int'(dst_w);
            dh = (int'(dst_h) > 512) ? 512 : int'(dst_h);
            target = in_words_q.size() + 142;
            while (in_words_q.size() < target) begin
                r = $urandom_range(0, 99);
                if (r < 30 && sw > 0 && sh > 0) begin
                    queue_word(OP_WRITE, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                               rand_pixel());
                end else if (r < 85 && dw > 0 && dh > 0) begin
                    x = ($urandom_range(0, 7) == 0) ? dw - 1 : $urandom_range(0, dw - 1);
                    y = ($urandom_range(0, 7) == 0) ? dh - 1 : $urandom_range(0, dh - 1);
                    queue_word(OP_READ, x, y, $urandom);
                end else begin
                    queue_word($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                               $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
                end
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
